// ----- hw/rtl/hsc_pkg.sv -----
// Shared types, constants and position helpers for the Hamming SEC codec.
package hsc_pkg;

    localparam int DATA_W    = 32;                 // widest data word
    localparam int PAR_W     = 6;                  // most parity bits
    localparam int CODE_W    = DATA_W + PAR_W;     // widest codeword
    localparam int SYN_W     = 6;
    localparam int DBITS_W   = 6;
    localparam int SHAMT_W   = 5;
    localparam int PCNT_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ODD_PARITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DATA_BITS  = 2'd1;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [DBITS_W-1:0] DATA_BITS_RESET  = 6'd8;
    localparam logic               ODD_PARITY_RESET = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] data_word;
        logic [CODE_W-1:0] code_word;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0] encoded_word;
        logic [DATA_W-1:0] decoded_data;
        logic [SYN_W-1:0]  syndrome;
        logic              error_found;
        logic              position_invalid;
    } t_out;

    // Settings derived from the configuration registers
    typedef struct packed {
        logic               odd;
        logic [DBITS_W-1:0] d;      // data bits in use, 1..DATA_W
        logic [SHAMT_W-1:0] shamt;  // DATA_W - d
        logic [PCNT_W-1:0]  p;      // parity bit count
        logic [DBITS_W-1:0] n;      // codeword length
    } t_cfg;

    function automatic t_cfg cfg_derive(logic odd, logic [DBITS_W-1:0] val);
        t_cfg               c;
        logic [DBITS_W-1:0] d;
        logic [PCNT_W-1:0]  p;
        d = val;
        if (val == '0) begin
            d = 6'd1;
        end else if (val > 6'(DATA_W)) begin
            d = 6'(DATA_W);
        end
        // smallest p with 2^p >= d + p + 1
        p = 3'(PAR_W);
        for (int i = PAR_W - 1; i >= 0; i--) begin
            if ((7'd1 << i) >= (7'(d) + 7'(i) + 7'd1)) begin
                p = 3'(i);
            end
        end
        c.odd   = odd;
        c.d     = d;
        c.shamt = 5'(6'(DATA_W) - d);
        c.p     = p;
        c.n     = d + 6'(p);
        return c;
    endfunction

    function automatic bit is_pow2(int pos);
        return (pos != 0) && ((pos & (pos - 1)) == 0);
    endfunction

    // Data slot index of a non-parity position (1-based position)
    function automatic int slot_of(int pos);
        int cnt;
        cnt = 0;
        for (int i = 0; i < PAR_W; i++) begin
            if ((1 << i) <= pos) begin
                cnt++;
            end
        end
        return pos - 1 - cnt;
    endfunction

    // Positions covered by the check of weight 2^i, bit k = position k+1
    function automatic logic [CODE_W-1:0] cover_mask(int i);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int k = 0; k < CODE_W; k++) begin
            m[k] = (((k + 1) >> i) & 1) != 0;
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/hsc_core.sv -----
// Combinational encode and check/correct datapath for one codeword.
module hsc_core
    import hsc_pkg::*;
(
    input  t_cfg i_cfg,
    input  t_in  i_item,
    output t_out o_res
);

    logic [DATA_W-1:0] enc_x;
    logic [CODE_W-1:0] enc_w;
    logic [CODE_W-1:0] nmask;
    logic [CODE_W-1:0] dec_w;
    logic [CODE_W-1:0] flip;
    logic [CODE_W-1:0] cor_w;
    logic [SYN_W-1:0]  syn;
    logic              err;
    logic              invalid;
    logic [DATA_W-1:0] slots;
    logic [DATA_W-1:0] slots_rev;
    logic [DATA_W-1:0] dec_data;

    // Encode: MSB of the used data lands in the lowest data slot
    always_comb begin
        enc_x = i_item.data_word << i_cfg.shamt;
        enc_w = '0;
        for (int pos = 1; pos <= CODE_W; pos++) begin
            if (!is_pow2(pos)) begin
                enc_w[pos-1] = enc_x[DATA_W-1-slot_of(pos)];
            end
        end
        for (int i = 0; i < PAR_W; i++) begin
            if (3'(i) < i_cfg.p) begin
                enc_w[(1 << i) - 1] = i_cfg.odd ^ (^(enc_w & cover_mask(i)));
            end
        end
    end

    // Decode: syndrome over positions 1..n, flip the named bit when in range
    always_comb begin
        nmask = ~({CODE_W{1'b1}} << i_cfg.n);
        dec_w = i_item.code_word & nmask;
        syn   = '0;
        for (int i = 0; i < PAR_W; i++) begin
            if (3'(i) < i_cfg.p) begin
                syn[i] = i_cfg.odd ^ (^(dec_w & cover_mask(i)));
            end
        end
        err     = (syn != '0);
        invalid = (syn > i_cfg.n);
        for (int pos = 1; pos <= CODE_W; pos++) begin
            flip[pos-1] = (syn == 6'(pos)) && !invalid;
        end
        cor_w = dec_w ^ flip;
        slots = '0;
        for (int pos = 1; pos <= CODE_W; pos++) begin
            if (!is_pow2(pos)) begin
                slots[slot_of(pos)] = cor_w[pos-1];
            end
        end
        for (int m = 0; m < DATA_W; m++) begin
            slots_rev[DATA_W-1-m] = slots[m];
        end
        dec_data = slots_rev >> i_cfg.shamt;
    end

    always_comb begin
        o_res = '0;
        if (i_item.mode == MODE_DECODE) begin
            o_res.decoded_data     = dec_data;
            o_res.syndrome         = syn;
            o_res.error_found      = err;
            o_res.position_invalid = invalid;
        end else begin
            o_res.encoded_word = enc_w;
        end
    end

endmodule

// ----- hw/rtl/hamming_sec_codec.sv -----
// Hamming SEC codec top level: config registers, input and result registers.
//
// Hamming single-error-correcting codec. Each transaction either encodes a data
// word (mode 0) or checks and corrects a codeword (mode 1) and produces exactly
// one result. One transaction is accepted per clock cycle while the result path
// is not held back by i_out_ready; the input register captures it, and its result
// then moves into the result register, where it is held until taken. One pass of
// shifters and XOR trees lies between the two registers. data_bits of 0 is taken
// as 1 and values above 32 as 32; the parity count and codeword length follow
// from it. Write configuration only while no transaction is in flight; the
// config port is always ready.
module hamming_sec_codec
    import hsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic r_s1_vld;
    t_in  r_s1;
    logic r_out_vld;
    t_out r_out;
    t_out core_res;
    logic out_load;
    logic in_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cfg_derive(ODD_PARITY_RESET, DATA_BITS_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_ODD_PARITY: r_cfg.odd <= i_cfg_data[0];
                CFG_IDX_DATA_BITS:  r_cfg     <= cfg_derive(r_cfg.odd, i_cfg_data);
                default: ;
            endcase
        end
    end

    hsc_core u_core (
        .i_cfg  (r_cfg),
        .i_item (r_s1),
        .o_res  (core_res)
    );

    // Advance the result register when empty or drained this cycle
    assign out_load   = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || out_load;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in_data;
        end
        if (out_load) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    logic [CODE_W-1:0] len_mask;
    assign len_mask = ~({CODE_W{1'b1}} << r_cfg.n);

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted transaction did not reach input register");

    a_err_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.error_found == (o_out_data.syndrome != '0)))
        else $error("error flag disagrees with syndrome");

    a_invalid_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.position_invalid |-> o_out_data.error_found)
        else $error("invalid position without error flag");

    a_enc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.encoded_word & ~len_mask) == '0))
        else $error("encoded bits beyond codeword length");

endmodule
